>>> src/ddpu_pkg.sv
// ----------------------------------------------------------------------------
// ddpu_pkg: shared constants and helpers for the differential-drive pose update
// Holds the register indexes, fixed-point constants, the arctangent table and
// the rounding shift used by the sequencer.
// ----------------------------------------------------------------------------
package ddpu_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic REG_WHEEL_RADIUS  = 1'b0;
  localparam logic REG_WHEEL_SPACING = 1'b1;

  localparam logic [7:0]  RADIUS_RST  = 8'd20;
  localparam logic [7:0]  SPACING_RST = 8'd30;
  localparam logic [31:0] HEADING_RST = 32'h2000_0000;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [25:0] PI_DEG_Q30      = 26'sd18740330;
  localparam logic [8:0]         TURN_DEG        = 9'd360;

  // divider widths: numerator and denominator magnitudes
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 34;

  // CORDIC datapath widths
  localparam int CW = 34;   // x and y
  localparam int ZW = 33;   // residual angle

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    if (v >= 0) begin
      mag = (64'(v) + half) >> s;
      return $signed(mag);
    end
    mag = (64'(-v) + half) >> s;
    return -$signed(mag);
  endfunction

endpackage

>>> src/ddpu_cordic.sv
// ----------------------------------------------------------------------------
// ddpu_cordic: iterative sine/cosine unit
// Rotation-mode CORDIC, one micro-rotation per cycle, quadrant folded at the
// output. Results are Q2.30, valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module ddpu_cordic #(
  parameter int CORDIC_STEPS = ddpu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         angle,
  output logic                done,
  output logic signed [34:0]  cos_out,
  output logic signed [34:0]  sin_out
);

  logic signed [ddpu_pkg::CW-1:0] x, y;
  logic signed [ddpu_pkg::ZW-1:0] z;
  logic [1:0] quad;
  logic [4:0] idx;
  logic       busy;
  logic signed [ddpu_pkg::ZW-1:0] at;

  assign at = $signed({1'b0, ddpu_pkg::atan_bam(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        x    <= ddpu_pkg::CORDIC_GAIN_Q30;
        y    <= '0;
        z    <= $signed({3'b000, angle[29:0]});
        quad <= angle[31:30];
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> idx);
          y <= y + (x >>> idx);
          z <= z - at;
        end else begin
          x <= x + (y >>> idx);
          y <= y - (x >>> idx);
          z <= z + at;
        end
        if (idx == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        idx <= idx + 5'd1;
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin cos_out = 35'(x);  sin_out = 35'(y);  end
      2'd1: begin cos_out = -35'(y); sin_out = 35'(x);  end
      2'd2: begin cos_out = -35'(x); sin_out = -35'(y); end
      default: begin cos_out = 35'(y); sin_out = -35'(x); end
    endcase
  end

endmodule

>>> src/ddpu_div.sv
// ----------------------------------------------------------------------------
// ddpu_div: restoring divider
// Unsigned, one quotient bit per cycle, MSB first. Keeps the low 32 bits of
// the quotient; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module ddpu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ddpu_pkg::DIV_NW-1:0] num,
  input  logic [ddpu_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [31:0]                 quo
);

  localparam int NW = ddpu_pkg::DIV_NW;
  localparam int DW = ddpu_pkg::DIV_DW;

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [NW-1:0] nsh;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fit;

  assign trial = {rem, nsh[NW-1]};
  assign fit   = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nsh  <= num;
        dreg <= den;
        quo  <= '0;
      end else if (busy) begin
        rem <= fit ? DW'(trial - {1'b0, dreg}) : DW'(trial);
        nsh <= {nsh[NW-2:0], 1'b0};
        quo <= {quo[30:0], fit};
        if (cnt == 6'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

endmodule

>>> src/differential_drive_pose_update.sv
// ----------------------------------------------------------------------------
// differential_drive_pose_update: wheel odometry pose update
// Takes per-tick wheel rotations, keeps x, y and heading, returns the new pose.
//
//   channel  | direction | payload
//   s_*      | in        | tdata: left_turn, right_turn
//   m_*      | out       | tdata: pos_x, pos_y, heading; tuser: went_straight
//   cfg_*    | in        | cfg_index, cfg_data (wheel_radius, wheel_spacing)
//
// Straight tick: one CORDIC pass and four products from accept to the output
// beat. Turning tick: two CORDIC passes and three passes of the bit-serial
// divider. s_tready is high only while the sequencer is idle, which it
// re-enters as the pose is loaded; a finished pose waits in S_UPD while the
// output register is full and m_tready is low.
// Reset restores radius 20, spacing 30 and the pose to origin at 45 degrees.
// ----------------------------------------------------------------------------
module differential_drive_pose_update #(
  parameter int CORDIC_STEPS = ddpu_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = ddpu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] left_turn, [19:10] right_turn, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] heading
  output logic        m_tuser,   // [0] went_straight
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int NW       = ddpu_pkg::DIV_NW;
  localparam int DW       = ddpu_pkg::DIV_DW;
  localparam int OUT_SH   = 45 - FRAC_BITS;
  localparam int DEN_SH   = 31 - FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_COS1 = 4'd1;
  localparam logic [3:0] S_ST1  = 4'd2;
  localparam logic [3:0] S_ST2  = 4'd3;
  localparam logic [3:0] S_ST3  = 4'd4;
  localparam logic [3:0] S_ST4  = 4'd5;
  localparam logic [3:0] S_DH   = 4'd6;
  localparam logic [3:0] S_DHW  = 4'd7;
  localparam logic [3:0] S_COS2 = 4'd8;
  localparam logic [3:0] S_TX1  = 4'd9;
  localparam logic [3:0] S_TX2  = 4'd10;
  localparam logic [3:0] S_TX3  = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;

  logic [3:0] state;
  logic [7:0] rad, spc;
  logic [31:0] cur_x, cur_y, cur_heading;

  logic signed [10:0] dv;
  logic signed [17:0] len;
  logic signed [18:0] num;
  logic               straight;
  logic               axis;
  logic               dsign;
  logic signed [34:0] c1, s1, c2;
  logic [31:0]        dx, dy, h2;
  logic signed [35:0] ma;
  logic signed [25:0] mb;
  logic signed [61:0] p;

  logic signed [9:0]  lt_in, rt_in;
  logic signed [10:0] dv_in, sv_in;
  logic [7:0]         spc_eff;
  logic               accept;

  logic               cord_start, cord_done;
  logic [31:0]        cord_angle;
  logic signed [34:0] cord_cos, cord_sin;

  logic               div_start, div_done;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic [31:0]        div_q, div_val;

  logic signed [19:0] rdv;
  logic [18:0]        rdv_mag;
  logic [16:0]        den_dh;
  logic [DW-1:0]      den_tx;
  logic [9:0]         dv_mag;
  logic [61:0]        p_mag;
  logic signed [63:0] rs_val;
  logic [31:0]        nx, ny;

  function automatic logic [16:0] TURN_MUL(input logic [7:0] s);
    return 17'(ddpu_pkg::TURN_DEG) * 17'(s);
  endfunction

  assign lt_in   = $signed(s_tdata[9:0]);
  assign rt_in   = $signed(s_tdata[19:10]);
  assign dv_in   = 11'(lt_in) - 11'(rt_in);
  assign sv_in   = 11'(lt_in) + 11'(rt_in);
  assign spc_eff = (spc == 8'd0) ? 8'd1 : spc;
  assign accept  = s_tvalid && s_tready;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign rdv     = $signed({1'b0, rad}) * dv;
  assign rdv_mag = rdv[19] ? 19'(-rdv) : 19'(rdv);
  assign den_dh  = 17'(TURN_MUL(spc_eff));
  assign dv_mag  = dv[10] ? 10'(-dv) : 10'(dv);
  assign den_tx  = DW'(dv_mag) << DEN_SH;
  assign p_mag   = p[61] ? 62'(-p) : 62'(p);
  assign div_val = dsign ? -div_q : div_q;
  assign rs_val  = (state == S_ST2) ? ddpu_pkg::rnd_shift(64'(p), 15)
                                    : ddpu_pkg::rnd_shift(64'(p), OUT_SH);
  assign nx      = cur_x + dx;
  assign ny      = cur_y + dy;

  // shared multiplier, registered every cycle
  always_ff @(posedge clk) begin
    p <= 62'(ma * mb);
  end

  assign cord_start = accept || (state == S_DHW && div_done);
  assign cord_angle = accept ? cur_heading : cur_heading + div_val;

  assign div_start = (state == S_DH) || (state == S_TX2);
  always_comb begin
    if (state == S_DH) begin
      div_num = (NW'(rdv_mag) << 32) + NW'(den_dh >> 1);
      div_den = DW'(den_dh);
    end else begin
      div_num = NW'(p_mag) + NW'(den_tx >> 1);
      div_den = den_tx;
    end
  end

  ddpu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_angle),
    .done(cord_done), .cos_out(cord_cos), .sin_out(cord_sin)
  );

  ddpu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rad         <= ddpu_pkg::RADIUS_RST;
      spc         <= ddpu_pkg::SPACING_RST;
      cur_x       <= '0;
      cur_y       <= '0;
      cur_heading <= ddpu_pkg::HEADING_RST;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ddpu_pkg::REG_WHEEL_RADIUS:  rad <= cfg_data;
          ddpu_pkg::REG_WHEEL_SPACING: spc <= cfg_data;
          default: ;
        endcase
      end
      // S_UPD reloads the output register itself
      if (m_tvalid && m_tready && state != S_UPD) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            dv       <= dv_in;
            len      <= 18'($signed({1'b0, rad}) * lt_in);
            num      <= 19'($signed({1'b0, spc_eff}) * sv_in);
            straight <= (dv_in == 11'sd0) || (rad == 8'd0);
            axis     <= 1'b0;
            state    <= S_COS1;
          end
        end
        S_COS1: begin
          if (cord_done) begin
            c1 <= cord_cos;
            s1 <= cord_sin;
            if (straight) begin
              ma    <= 36'(cord_cos);
              mb    <= 26'(len);
              state <= S_ST1;
            end else begin
              state <= S_DH;
            end
          end
        end
        S_ST1: state <= S_ST2;
        S_ST2: begin
          ma    <= 36'(rs_val);
          mb    <= ddpu_pkg::PI_DEG_Q30;
          state <= S_ST3;
        end
        S_ST3: state <= S_ST4;
        S_ST4: begin
          if (!axis) begin
            dx    <= 32'(rs_val);
            axis  <= 1'b1;
            ma    <= 36'(s1);
            mb    <= 26'(len);
            state <= S_ST1;
          end else begin
            dy    <= 32'(rs_val);
            state <= S_UPD;
          end
        end
        S_DH: begin
          dsign <= rdv[19];
          state <= S_DHW;
        end
        S_DHW: begin
          if (div_done) begin
            h2    <= cur_heading + div_val;
            state <= S_COS2;
          end
        end
        S_COS2: begin
          if (cord_done) begin
            c2    <= cord_cos;
            ma    <= 36'(cord_sin) - 36'(s1);
            mb    <= 26'(num);
            state <= S_TX1;
          end
        end
        S_TX1: state <= S_TX2;
        S_TX2: begin
          dsign <= p[61] ^ dv[10];
          state <= S_TX3;
        end
        S_TX3: begin
          if (div_done) begin
            if (!axis) begin
              dx    <= div_val;
              axis  <= 1'b1;
              ma    <= 36'(c1) - 36'(c2);
              mb    <= 26'(num);
              state <= S_TX1;
            end else begin
              dy    <= div_val;
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            cur_x    <= nx;
            cur_y    <= ny;
            if (!straight) cur_heading <= h2;
            m_tdata  <= {(straight ? cur_heading : h2), ny, nx};
            m_tuser  <= straight;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/tb_differential_drive_pose_update.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_pose_update: self-checking bench for the pose update
// Drives wheel-turn beats with random gaps, predicts each pose with a local
// fixed-point odometry model and compares every output beat field by field.
// Covers register settings including extremes, straight and turning ticks,
// a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_differential_drive_pose_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = ddpu_pkg::CORDIC_STEPS_DEF;
  localparam int FRAC  = ddpu_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [9:0] left;
    logic signed [9:0] right;
  } tick_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hd;
    logic        straight;
  } pose_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  differential_drive_pose_update u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // odometry state of the predictor
  logic [7:0]  radius_q;
  logic [7:0]  spacing_q;
  logic [31:0] x_q = '0;
  logic [31:0] y_q = '0;
  logic [31:0] hd_q = ddpu_pkg::HEADING_RST;

  tick_t pending_ticks[$];
  pose_t expected_poses[$];
  int    errors = 0;
  int    idle_cycles;
  bit    hold_output;
  int    hold_count;
  int    send_gap;
  int    recv_gap;
  logic  s_taken;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint round_quot(longint n, longint d);
    longint un, ud, q;
    bit neg;
    neg = 0;
    un = n; ud = d;
    if (n < 0) begin un = -n; neg = !neg; end
    if (d < 0) begin ud = -d; neg = !neg; end
    q = (un + ud / 2) / ud;
    return neg ? -q : q;
  endfunction

  task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
    longint cx, cy, z, nx;
    logic [1:0] quad;
    quad = ang[31:30];
    z = longint'(ang[29:0]);
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = cx - floor_sh(cy, i);
        cy = cy + floor_sh(cx, i);
        z -= longint'(ddpu_pkg::atan_bam(5'(i)));
      end else begin
        nx = cx + floor_sh(cy, i);
        cy = cy - floor_sh(cx, i);
        z += longint'(ddpu_pkg::atan_bam(5'(i)));
      end
      cx = nx;
    end
    case (quad)
      2'd0: begin c = cx;  s = cy;  end
      2'd1: begin c = -cy; s = cx;  end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endtask

  task automatic predict_pose(input tick_t t);
    longint lt, rt, dv, sv, rad, spc, c1, s1, c2, s2, dx, dy, dh, len, num, den;
    logic [31:0] h2;
    bit straight;
    pose_t p;
    lt = longint'(t.left);
    rt = longint'(t.right);
    dv = lt - rt;
    sv = lt + rt;
    rad = longint'(radius_q);
    spc = (spacing_q == 0) ? 1 : longint'(spacing_q);
    straight = (dv == 0) || (rad == 0);
    cordic(hd_q, c1, s1);
    if (straight) begin
      len = rad * lt;
      dx = round_sh(round_sh(len * c1, 15) * 18740330, 45 - FRAC);
      dy = round_sh(round_sh(len * s1, 15) * 18740330, 45 - FRAC);
    end else begin
      dh = round_quot(rad * dv * 64'sd4294967296, 360 * spc);
      h2 = hd_q + dh[31:0];
      cordic(h2, c2, s2);
      num = spc * sv;
      den = dv * (longint'(1) << (31 - FRAC));
      dx = round_quot(num * (s2 - s1), den);
      dy = round_quot(num * (c1 - c2), den);
      hd_q = h2;
    end
    x_q += dx[31:0];
    y_q += dy[31:0];
    p.x = x_q; p.y = y_q; p.hd = hd_q; p.straight = straight;
    expected_poses = {expected_poses, p};
  endtask

  task automatic queue_tick(input tick_t t);
    pending_ticks = {pending_ticks, t};
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: one tick beat per entry of pending_ticks
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata  <= '0;
      send_gap <= 0;
    end else if (s_tvalid && !s_taken) begin
      // hold the beat
    end else if (send_gap > 0) begin
      s_tvalid <= 0;
      send_gap <= send_gap - 1;
    end else if (pending_ticks.size() > 0) begin
      s_tvalid <= 1;
      s_tdata  <= {4'd0, pending_ticks[0].right, pending_ticks[0].left};
      void'(pending_ticks.pop_front());
      send_gap <= $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
    end else begin
      s_tvalid <= 0;
    end
  end

  // predict when a tick beat is taken
  always @(posedge clk) begin
    s_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      predict_pose(tick_t'({s_tdata[9:0], s_tdata[19:10]}));
  end

  // receiver readiness with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
      recv_gap <= 0;
      hold_count <= 0;
    end else if (hold_output && hold_count < 3000) begin
      m_tready <= 0;
      hold_count <= hold_count + 1;
    end else if (recv_gap > 0) begin
      m_tready <= 0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_tready <= 1;
      if (m_tvalid && m_tready) recv_gap <= $urandom_range(0, 6) * $urandom_range(0, 1);
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose beat x=%h y=%h h=%h s=%b", $time,
                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (m_tdata[31:0] !== want.x) begin
          $display("%0t: pos_x expected %h got %h", $time, want.x, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== want.y) begin
          $display("%0t: pos_y expected %h got %h", $time, want.y, m_tdata[63:32]);
          errors++;
        end
        if (m_tdata[95:64] !== want.hd) begin
          $display("%0t: heading expected %h got %h", $time, want.hd, m_tdata[95:64]);
          errors++;
        end
        if (m_tuser !== want.straight) begin
          $display("%0t: went_straight expected %b got %b", $time, want.straight,
                   m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ticks.size() > 0 || s_tvalid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == ddpu_pkg::REG_WHEEL_RADIUS) radius_q = val;
    else spacing_q = val;
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    int k;
    k = $urandom_range(0, 9);
    t.left = 10'($urandom);
    if (k == 0) t.right = t.left;
    else if (k < 6) t.right = 10'(int'(t.left) + int'($urandom_range(0, 60)) - 30);
    else t.right = 10'($urandom);
    if (t.right == t.left && k != 0) t.right = 10'($urandom);
    return t;
  endfunction

  initial begin
    logic [7:0] radii[5];
    logic [7:0] spacings[5];
    hold_output = 0;
    radius_q = ddpu_pkg::RADIUS_RST; spacing_q = ddpu_pkg::SPACING_RST;
    cfg_valid = 0; cfg_index = ddpu_pkg::REG_WHEEL_RADIUS; cfg_data = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed ticks at reset settings
    queue_tick('{left: 10'sd0,    right: 10'sd0});
    queue_tick('{left: 10'sd511,  right: 10'sd511});
    queue_tick('{left: -10'sd512, right: -10'sd512});
    queue_tick('{left: 10'sd511,  right: -10'sd512});
    queue_tick('{left: -10'sd512, right: 10'sd511});
    queue_tick('{left: 10'sd90,   right: 10'sd30});
    queue_tick('{left: 10'sd10,   right: -10'sd10});
    queue_tick('{left: 10'sd1,    right: 10'sd0});
    queue_tick('{left: -10'sd1,   right: 10'sd0});
    queue_tick('{left: 10'sd0,    right: 10'sd511});
    drain();

    // extreme registers: radius 255, spacing 1, then spacing 0 and radius 0
    write_reg(ddpu_pkg::REG_WHEEL_RADIUS, 8'd255);
    write_reg(ddpu_pkg::REG_WHEEL_SPACING, 8'd1);
    queue_tick('{left: 10'sd511, right: -10'sd512});
    queue_tick('{left: 10'sd200, right: 10'sd200});
    queue_tick('{left: 10'sd5,   right: 10'sd4});
    drain();
    write_reg(ddpu_pkg::REG_WHEEL_SPACING, 8'd0);
    write_reg(ddpu_pkg::REG_WHEEL_RADIUS, 8'd0);
    queue_tick('{left: 10'sd300, right: -10'sd100});
    queue_tick('{left: 10'sd7,   right: 10'sd7});
    drain();

    radii    = '{8'd1, 8'd255, 8'd20, 8'd0, 8'd137};
    spacings = '{8'd255, 8'd1, 8'd30, 8'd77, 8'd0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_reg(ddpu_pkg::REG_WHEEL_RADIUS, radii[ph]);
        write_reg(ddpu_pkg::REG_WHEEL_SPACING, spacings[ph]);
      end else begin
        write_reg(ddpu_pkg::REG_WHEEL_RADIUS, 8'($urandom_range(1, 255)));
        write_reg(ddpu_pkg::REG_WHEEL_SPACING, 8'($urandom));
      end
      // phase 2 stalls the output long enough to back up the input
      if (ph == 2) hold_output = 1;
      for (int i = 0; i < 300; i++) queue_tick(rand_tick());
      drain();
      hold_output = 0;
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
